// File: src/eti_pkg.sv
// ----------------------------------------------------------------------------
// eti_pkg: shared definitions of the eased tween interpolator
// Codes, fixed-point constants, curve table builders and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package eti_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_EASING     = 3'd0;
    localparam logic [2:0] REG_OUT_MODE   = 3'd1;
    localparam logic [2:0] REG_DURATION   = 3'd2;
    localparam logic [2:0] REG_DELAY      = 3'd3;
    localparam logic [2:0] REG_START_GEO  = 3'd4;
    localparam logic [2:0] REG_END_GEO    = 3'd5;
    localparam logic [2:0] REG_START_SKEW = 3'd6;
    localparam logic [2:0] REG_END_SKEW   = 3'd7;

    // Easing codes.
    localparam logic [2:0] EASE_LINEAR  = 3'd0;
    localparam logic [2:0] EASE_EXP_OUT = 3'd1;
    localparam logic [2:0] EASE_EXP_IN  = 3'd2;
    localparam logic [2:0] EASE_ELASTIC = 3'd3;
    localparam logic [2:0] EASE_BACK    = 3'd4;

    // Output modes.
    localparam logic [1:0] OMODE_SINGLE   = 2'd0;
    localparam logic [1:0] OMODE_GEOMETRY = 2'd1;
    localparam logic [1:0] OMODE_SKEW     = 2'd2;

    // Animation phases.
    localparam logic [1:0] PH_ARMED   = 2'd0;
    localparam logic [1:0] PH_WAITING = 2'd1;
    localparam logic [1:0] PH_ANIM    = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    // Input opcodes.
    localparam logic OPC_ARM  = 1'b0;
    localparam logic OPC_TICK = 1'b1;

    // Datapath operations.
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_TAB   = 3'd1;
    localparam logic [2:0] OP_SQ    = 3'd2;
    localparam logic [2:0] OP_C3    = 3'd3;
    localparam logic [2:0] OP_FIN   = 3'd4;
    localparam logic [2:0] OP_BLEND = 3'd5;

    localparam int unsigned GAP_MS   = 10;
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned LANES    = 4;

    // Q16 constants of the curves.
    localparam logic signed [23:0] ONE_Q16     = 24'sd65536;
    localparam logic signed [23:0] TWO_Q16     = 24'sd131072;
    localparam logic signed [23:0] BACK_C2_Q16 = 24'sd170060;
    localparam logic signed [23:0] BACK_C3_Q16 = 24'sd235596;
    // Elastic angle offset: 0.75 turn scaled by 3 in Q16, and 1/3 as 2^21 reciprocal.
    localparam logic [20:0] ELASTIC_OFS = 21'd147456;
    localparam logic [20:0] RECIP3_Q21  = 21'd699051;

    localparam longint unsigned LN2_Q30     = 64'd744261118;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic       capture;
        logic       load_created;
        logic       load_start;
        logic       div_step;
        logic [2:0] op;
        logic [2:0] lane;
        logic       set_last;
        logic       load_out;
        logic       upd;
        logic [1:0] phase;
    } cmd_t;

    typedef struct packed {
        logic delay_done;
        logic gap_ok;
        logic t_full_now;
        logic t_full;
        logic out_free;
    } status_t;

    // Q16 value of 2^(-i/n), built by a Taylor series in Q30.
    function automatic logic [16:0] exp_entry(input int unsigned i, input int unsigned n);
        longint unsigned x;
        longint unsigned term;
        longint sum;
        x = (64'(i) * LN2_Q30) / 64'(n);
        term = 64'd1 << 30;
        sum = longint'(term);
        for (int k = 1; k <= 20; k++)
        begin
            term = ((term * x) >> 30) / 64'(k);
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        return 17'((sum + 8192) >>> 14);
    endfunction

    // Q16 value of sin(2*pi*i/n), built by a Taylor series in Q30.
    function automatic logic signed [17:0] sin_entry(input int unsigned i, input int unsigned n);
        longint unsigned q;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned num;
        longint unsigned a;
        longint unsigned term;
        longint sum;
        longint mag;
        q = 64'(4 * i);
        quad = q / 64'(n);
        rem = q % 64'(n);
        num = quad[0] ? 64'(n) - rem : rem;
        a = (num * HALF_PI_Q30) / 64'(n);
        term = a;
        sum = longint'(a);
        for (int k = 1; k <= 10; k++)
        begin
            term = (term * a) >> 30;
            term = ((term * a) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        mag = (sum + 8192) >>> 14;
        if (quad >= 2)
            mag = -mag;
        return 18'(mag);
    endfunction

endpackage

// File: src/eased_tween_interpolator.sv
// ----------------------------------------------------------------------------
// eased_tween_interpolator: one animation channel with eased interpolation
// Arm and tick requests drive a delayed, throttled tween of x, y, width,
// height and skew along one of five easing curves.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   s_axis   | tvalid/tready         | tuser: opcode; tdata: now_ms
//   m_axis   | tvalid/tready         | tuser: update, skew flag, phase;
//            |                       | tdata: x, y, w, h, skew
//   cfg      | cfg_valid/cfg_ready   | cfg_addr: register, cfg_data: value
//
// An update runs the radix-2 divider of elapsed time over duration, then
// 4 easing steps (a table lookup, then the rest through the one shared
// multiplier) and 5 blend steps through it, then loads the output.
// An update that reaches t = 1 skips the divider.
// A new request is taken while the previous result waits in the output register.
// Reset is asynchronous and active low; configuration is always accepted.
// ----------------------------------------------------------------------------
module eased_tween_interpolator
    import eti_pkg::*;
#(
    parameter int TIME_BITS           = 32,
    parameter int COORD_BITS          = 12,
    parameter int CURVE_TABLE_ENTRIES = 256
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [31:0]                              s_axis_tdata,  // now_ms
    input  logic [0:0]                               s_axis_tuser,  // opcode
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // pos_x, pos_y, size_w, size_h, skew_out, zero fill
    output logic [((4*COORD_BITS+16+7)/8)*8-1:0]     m_axis_tdata,
    // update_valid, skew_valid, phase_out
    output logic [3:0]                               m_axis_tuser,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [2:0]                               cfg_addr,
    input  logic [4*COORD_BITS-1:0]                  cfg_data
);

    localparam int OUT_W = ((4 * COORD_BITS + 16 + 7) / 8) * 8;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    eti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .opcode   (s_axis_tuser[0]),
        .status   (status),
        .cmd      (cmd)
    );

    eti_datapath #(
        .TIME_BITS           (TIME_BITS),
        .COORD_BITS          (COORD_BITS),
        .CURVE_TABLE_ENTRIES (CURVE_TABLE_ENTRIES),
        .OUT_W               (OUT_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .now_in    (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

    // One request at a time: the input closes right after a request.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a request is in progress");

    a_skew_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("skew flagged without an update");

    a_update_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tuser[3:2] == PH_ANIM) || (m_axis_tuser[3:2] == PH_DONE))
        else $error("update reported outside the motion phases");

endmodule

// File: src/eti_ctrl.sv
// ----------------------------------------------------------------------------
// eti_ctrl: sequencer of the eased tween interpolator
// Tracks the animation phase and steps the datapath through division,
// easing and the five blend lanes of an update.
// ----------------------------------------------------------------------------
module eti_ctrl
    import eti_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    opcode,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_TAB   = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_C3    = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_BLEND = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [1:0] phase_reg, phase_next;
    logic       upd_reg, upd_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        phase_next = phase_reg;
        upd_next = upd_reg;
        cmd = '0;
        cmd.op = OP_NONE;
        cmd.lane = cnt_reg[2:0];
        cmd.upd = upd_reg;
        cmd.phase = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    upd_next = 1'b0;
                    cnt_next = '0;
                    state_next = S_DONE;
                    if (opcode == OPC_ARM)
                        phase_next = PH_ARMED;
                    else if (phase_reg == PH_ARMED)
                    begin
                        cmd.load_created = 1'b1;
                        phase_next = PH_WAITING;
                    end
                    else if (phase_reg == PH_WAITING)
                    begin
                        if (status.delay_done)
                        begin
                            cmd.load_start = 1'b1;
                            phase_next = PH_ANIM;
                        end
                    end
                    else if (phase_reg == PH_ANIM && status.gap_ok)
                    begin
                        upd_next = 1'b1;
                        state_next = status.t_full_now ? S_TAB : S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(DIV_STEPS - 1))
                begin
                    cnt_next = '0;
                    state_next = S_TAB;
                end
            end
            S_TAB:
            begin
                cmd.op = OP_TAB;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op = OP_SQ;
                state_next = S_C3;
            end
            S_C3:
            begin
                cmd.op = OP_C3;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op = OP_FIN;
                cnt_next = '0;
                state_next = S_BLEND;
            end
            S_BLEND:
            begin
                cmd.op = OP_BLEND;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(LANES))
                begin
                    cmd.set_last = 1'b1;
                    if (status.t_full)
                        phase_next = PH_DONE;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            phase_reg <= PH_ARMED;
            upd_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            phase_reg <= phase_next;
            upd_reg <= upd_next;
        end
    end

endmodule

// File: src/eti_datapath.sv
// ----------------------------------------------------------------------------
// eti_datapath: arithmetic and storage of the eased tween interpolator
// Configuration registers, timestamps, a radix-2 divider, the curve tables,
// one shared signed multiplier, the blend lanes and the output register.
// ----------------------------------------------------------------------------
module eti_datapath
    import eti_pkg::*;
#(
    parameter int TIME_BITS           = 32,
    parameter int COORD_BITS          = 12,
    parameter int CURVE_TABLE_ENTRIES = 256,
    parameter int OUT_W               = ((4 * COORD_BITS + 16 + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic [31:0]               now_in,
    input  logic                      cfg_valid,
    input  logic [2:0]                cfg_addr,
    input  logic [4*COORD_BITS-1:0]   cfg_data,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [OUT_W-1:0]          out_data,
    output logic [3:0]                out_user
);

    localparam int TB       = TIME_BITS;
    localparam int CB       = COORD_BITS;
    localparam int N        = CURVE_TABLE_ENTRIES;
    localparam int IDX_BITS = $clog2(N);
    localparam logic signed [23:0] C_HI = 24'((1 << (CB - 1)) - 1);
    localparam logic signed [23:0] C_LO = -C_HI - 24'sd1;
    localparam logic signed [23:0] S_HI = 24'sd32767;
    localparam logic signed [23:0] S_LO = -24'sd32768;

    logic [2:0]           easing_reg;
    logic [1:0]           omode_reg;
    logic [15:0]          dur_reg, delay_reg;
    logic [4*CB-1:0]      sgeo_reg, egeo_reg;
    logic signed [15:0]   sskew_reg, eskew_reg;
    logic [TB-1:0]        created_reg, mstart_reg, last_reg, now_reg;
    logic                 tfull_reg;
    logic [16:0]          rem_reg;
    logic [15:0]          quo_reg;
    logic [16:0]          e_reg;
    logic signed [17:0]   s_reg;
    logic signed [23:0]   a_reg, b_reg, k_reg;
    logic [CB-1:0]        res_geo_reg [LANES];
    logic [15:0]          res_skew_reg;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;
    logic [3:0]           out_user_reg;

    logic [16:0]          exp_rom [N];
    logic signed [17:0]   sin_rom [N];

    for (genvar g = 0; g < N; g++)
    begin : g_rom
        assign exp_rom[g] = exp_entry(g, N);
        assign sin_rom[g] = sin_entry(g, N);
    end

    // Timing status, evaluated against the timestamp on the input port.
    logic [TB-1:0] now_t, el_now;
    assign now_t = now_in[TB-1:0];
    assign el_now = now_t - mstart_reg;
    assign status.delay_done = (now_t - created_reg) >= TB'(delay_reg);
    assign status.gap_ok = (now_t - last_reg) > TB'(GAP_MS);
    assign status.t_full_now = (dur_reg == '0) || (el_now >= TB'(dur_reg));
    assign status.t_full = tfull_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    // Divider step: the remainder stays below the duration.
    logic [16:0] rem_sh;
    logic        q_bit;
    assign rem_sh = {rem_reg[15:0], 1'b0};
    assign q_bit = rem_sh >= {1'b0, dur_reg};

    // Curve lookups.
    logic [15:0]          t16;
    logic [20:0]          u_fwd, u_rev, u_sel, x3;
    logic [31:0]          fr_prod, tr_prod;
    logic [41:0]          q3_prod;
    logic [15:0]          tfrac;
    logic [IDX_BITS-1:0]  e_idx, s_idx;
    logic [16:0]          exp_val;
    logic signed [18:0]   tw;

    assign t16 = quo_reg;
    assign u_fwd = ({5'b0, t16} << 3) + ({5'b0, t16} << 1);
    assign u_rev = 21'(21'd10 * (21'd65536 - {5'b0, t16}));
    assign u_sel = (easing_reg == EASE_EXP_IN) ? u_rev : u_fwd;
    assign fr_prod = 32'(u_sel[15:0]) * 32'(N);
    assign e_idx = fr_prod[16 +: IDX_BITS];
    assign exp_val = (u_sel[20:16] > 5'd16) ? 17'd0 : (exp_rom[e_idx] >> u_sel[20:16]);
    assign x3 = u_fwd + ELASTIC_OFS;
    assign q3_prod = 42'(x3) * 42'(RECIP3_Q21);
    assign tfrac = q3_prod[36:21];
    assign tr_prod = 32'(tfrac) * 32'(N);
    assign s_idx = tr_prod[16 +: IDX_BITS];
    assign tw = $signed({2'b00, t16, 1'b0}) - (t16[15] ? 19'sd131072 : 19'sd0);

    // Shared multiplier and its operand selection.
    logic signed [23:0] mul_a, mul_b, lane_s, lane_e, p_floor, p_trunc;
    logic signed [47:0] prod;
    logic signed [23:0] k_val, blend_sum, blend_sat;
    logic [1:0]         gl;

    assign gl = cmd.lane[1:0];

    always_comb
    begin
        if (cmd.lane == 3'(LANES))
        begin
            lane_s = 24'(sskew_reg);
            lane_e = 24'(eskew_reg);
        end
        else
        begin
            lane_s = 24'($signed(sgeo_reg[gl*CB +: CB]));
            lane_e = 24'($signed(egeo_reg[gl*CB +: CB]));
        end
    end

    always_comb
    begin
        case (cmd.op)
            OP_SQ:
            begin
                mul_a = 24'(tw);
                mul_b = 24'(tw);
            end
            OP_C3:
            begin
                mul_a = BACK_C3_Q16;
                mul_b = 24'(tw);
            end
            OP_FIN:
            begin
                if (easing_reg == EASE_ELASTIC)
                begin
                    mul_a = $signed({7'b0, e_reg});
                    mul_b = 24'(s_reg);
                end
                else
                begin
                    mul_a = a_reg;
                    mul_b = b_reg;
                end
            end
            OP_BLEND:
            begin
                mul_a = k_reg;
                mul_b = lane_e - lane_s;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign p_floor = prod[39:16];
    assign p_trunc = p_floor + ((prod[47] && (prod[15:0] != '0)) ? 24'sd1 : 24'sd0);

    always_comb
    begin
        case (easing_reg)
            EASE_EXP_OUT: k_val = ONE_Q16 - $signed({7'b0, e_reg});
            EASE_EXP_IN:  k_val = (t16 == '0) ? 24'sd0 : $signed({7'b0, e_reg});
            EASE_ELASTIC: k_val = p_floor + ONE_Q16;
            EASE_BACK:    k_val = (p_floor + (t16[15] ? TWO_Q16 : 24'sd0)) >>> 1;
            default:      k_val = $signed({8'b0, t16});
        endcase
        if (tfull_reg)
            k_val = ONE_Q16;
    end

    assign blend_sum = lane_s + p_trunc;

    always_comb
    begin
        if (cmd.lane == 3'(LANES))
            blend_sat = (blend_sum > S_HI) ? S_HI : ((blend_sum < S_LO) ? S_LO : blend_sum);
        else
            blend_sat = (blend_sum > C_HI) ? C_HI : ((blend_sum < C_LO) ? C_LO : blend_sum);
    end

    // Result assembly with the masks of the output mode.
    logic            skv;
    logic [CB-1:0]   o_x, o_y, o_w, o_h;
    logic [15:0]     o_skew;
    logic            geo_on;

    assign skv = cmd.upd && (omode_reg == OMODE_SKEW);
    assign geo_on = cmd.upd && (omode_reg != OMODE_SINGLE);
    assign o_x = cmd.upd ? res_geo_reg[0] : '0;
    assign o_y = geo_on ? res_geo_reg[1] : '0;
    assign o_w = geo_on ? res_geo_reg[2] : '0;
    assign o_h = geo_on ? res_geo_reg[3] : '0;
    assign o_skew = skv ? res_skew_reg : '0;

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign out_user = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            easing_reg <= EASE_LINEAR;
            omode_reg <= OMODE_GEOMETRY;
            dur_reg <= '0;
            delay_reg <= '0;
            sgeo_reg <= '0;
            egeo_reg <= '0;
            sskew_reg <= '0;
            eskew_reg <= '0;
            created_reg <= '0;
            mstart_reg <= '0;
            last_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_addr)
                    REG_EASING:     easing_reg <= cfg_data[2:0];
                    REG_OUT_MODE:   omode_reg <= cfg_data[1:0];
                    REG_DURATION:   dur_reg <= cfg_data[15:0];
                    REG_DELAY:      delay_reg <= cfg_data[15:0];
                    REG_START_GEO:  sgeo_reg <= cfg_data;
                    REG_END_GEO:    egeo_reg <= cfg_data;
                    REG_START_SKEW: sskew_reg <= cfg_data[15:0];
                    REG_END_SKEW:   eskew_reg <= cfg_data[15:0];
                    default:        ;
                endcase
            end
            if (cmd.load_created)
                created_reg <= now_t;
            if (cmd.load_start)
            begin
                mstart_reg <= now_t;
                last_reg <= now_t;
            end
            if (cmd.set_last)
                last_reg <= now_reg;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg <= now_t;
            tfull_reg <= status.t_full_now;
            rem_reg <= {1'b0, el_now[15:0]};
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= q_bit ? (rem_sh - {1'b0, dur_reg}) : rem_sh;
            quo_reg <= {quo_reg[14:0], q_bit};
        end
        case (cmd.op)
            OP_TAB:
            begin
                e_reg <= exp_val;
                s_reg <= sin_rom[s_idx];
            end
            OP_SQ:    a_reg <= p_floor;
            OP_C3:    b_reg <= p_floor + (t16[15] ? BACK_C2_Q16 : -BACK_C2_Q16);
            OP_FIN:   k_reg <= k_val;
            OP_BLEND:
            begin
                if (cmd.lane == 3'(LANES))
                    res_skew_reg <= blend_sat[15:0];
                else
                    res_geo_reg[gl] <= blend_sat[CB-1:0];
            end
            default: ;
        endcase
        if (cmd.load_out)
        begin
            out_data_reg <= OUT_W'({o_skew, o_h, o_w, o_y, o_x});
            out_user_reg <= {cmd.phase, skv, cmd.upd};
        end
    end

endmodule
